/* sv/sbma_pkg.sv */
// Shared types and codes for the segmented byte memory access block.
package sbma_pkg;

    typedef logic [1:0] t_size;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_region_sel;

    localparam logic  OP_READ  = 1'b0;
    localparam logic  OP_WRITE = 1'b1;

    localparam t_size SIZE_BYTE    = 2'd0;
    localparam t_size SIZE_HALF    = 2'd1;
    localparam t_size SIZE_WORD    = 2'd2;
    localparam t_size SIZE_INVALID = 2'd3;

    localparam t_status STATUS_OK       = 2'd0;
    localparam t_status STATUS_BAD_SIZE = 2'd1;
    localparam t_status STATUS_UNMAPPED = 2'd2;
    localparam t_status STATUS_BEYOND   = 2'd3;

    localparam logic [11:0] REGION_PROGRAM = 12'h004;
    localparam logic [11:0] REGION_DATA    = 12'h100;
    localparam logic [11:0] REGION_STACK   = 12'h7FF;

    localparam t_region_sel SEL_PROGRAM = 2'd0;
    localparam t_region_sel SEL_DATA    = 2'd1;
    localparam t_region_sel SEL_STACK   = 2'd2;

    // Control of one memory access: lane 0 holds the most significant byte.
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [3:0] byte_en;
    } t_ram_ctl;

endpackage

/* sv/sbma_if.sv */
// Valid/ready channel interfaces for access requests and their results.
interface sbma_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [1:0]  size;

    modport source (output valid, output op, output address, output write_data,
                    output size, input ready);
    modport sink   (input valid, input op, input address, input write_data,
                    input size, output ready);
endinterface

interface sbma_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [1:0]  status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink   (input valid, input read_data, input status, output ready);
endinterface

/* sv/segmented_byte_memory_access.sv */
// Top level of the segmented big-endian byte memory with byte, half and word access.
//
// Requests arrive on i_in (op, address, write_data, size) and each transfer yields
// exactly one result on o_out (read_data, status). Address bits 31..20 select the
// program (0x004), data (0x100) or stack (0x7FF) store; half and word accesses are
// aligned by clearing their low offset bits. Bytes are stored most significant
// first, reads are zero-extended, a write returns 1 and any error returns 0 with
// its status code.
// A result passes through the synchronous memory read and then the output register.
// Throughput is one access per cycle while the receiver does not stall, set by the
// single memory port that a read or a write uses once. A write in one cycle is seen
// by a read in the next.
// Reset clears the pipeline valid bits only; store contents are undefined until
// written and there is no clearing pass. When the receiver stalls, the result
// holds in the output register, one more access waits in the memory read
// register, and i_in.ready drops until the output moves.
module segmented_byte_memory_access #(
    parameter int OFFSET_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbma_in_if.sink    i_in,
    sbma_out_if.source o_out
);
    import sbma_pkg::*;

    localparam int ADDR_BITS = OFFSET_BITS;

    // Request decode.
    logic                 accept;
    logic [11:0]          region;
    logic [19:0]          offset;
    t_region_sel          sel;
    logic                 mapped;
    t_status              req_status;
    t_ram_ctl             ram_ctl;
    logic [ADDR_BITS-1:0] ram_addr;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;
    logic [3:0]           byte_en;

    // Stage after the memory read.
    logic       r_s1_valid;
    logic       r_s1_op;
    t_size      r_s1_size;
    logic [1:0] r_s1_lane;
    t_status    r_s1_status;
    logic       s1_adv;
    logic [31:0] s1_value;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_data;
    t_status     r_out_status;

    assign region = i_in.address[31:20];
    assign offset = i_in.address[19:0];

    always_comb begin
        mapped = 1'b1;
        sel    = SEL_PROGRAM;
        if (region == REGION_PROGRAM) begin
            sel = SEL_PROGRAM;
        end else if (region == REGION_DATA) begin
            sel = SEL_DATA;
        end else if (region == REGION_STACK) begin
            sel = SEL_STACK;
        end else begin
            mapped = 1'b0;
        end
    end

    // Alignment only clears bits below 2, so the range check uses the raw offset.
    always_comb begin
        if (i_in.size == SIZE_INVALID) begin
            req_status = STATUS_BAD_SIZE;
        end else if (!mapped) begin
            req_status = STATUS_UNMAPPED;
        end else if ((offset >> OFFSET_BITS) != 20'd0) begin
            req_status = STATUS_BEYOND;
        end else begin
            req_status = STATUS_OK;
        end
    end

    always_comb begin
        case (i_in.size)
            SIZE_BYTE: begin
                byte_en   = 4'b0001 << offset[1:0];
                ram_wdata = {4{i_in.write_data[7:0]}};
            end
            SIZE_HALF: begin
                byte_en   = offset[1] ? 4'b1100 : 4'b0011;
                ram_wdata = {2{i_in.write_data[15:0]}};
            end
            SIZE_WORD: begin
                byte_en   = 4'b1111;
                ram_wdata = i_in.write_data;
            end
            default: begin
                byte_en   = 4'b0000;
                ram_wdata = i_in.write_data;
            end
        endcase
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign accept     = i_in.valid && i_in.ready;

    assign ram_addr        = {sel, offset[OFFSET_BITS-1:2]};
    assign ram_ctl.wr      = accept && (req_status == STATUS_OK) && (i_in.op == OP_WRITE);
    assign ram_ctl.rd      = accept && (req_status == STATUS_OK) && (i_in.op == OP_READ);
    assign ram_ctl.byte_en = byte_en;

    sbma_ram #(
        .ADDR_BITS(ADDR_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_ctl  (ram_ctl),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    // The memory word holds offset 0 of the word in its top byte.
    always_comb begin
        s1_value = 32'd0;
        if (r_s1_status != STATUS_OK) begin
            s1_value = 32'd0;
        end else if (r_s1_op == OP_WRITE) begin
            s1_value = 32'd1;
        end else begin
            case (r_s1_size)
                SIZE_BYTE: begin
                    case (r_s1_lane)
                        2'd0:    s1_value = {24'd0, ram_rdata[31:24]};
                        2'd1:    s1_value = {24'd0, ram_rdata[23:16]};
                        2'd2:    s1_value = {24'd0, ram_rdata[15:8]};
                        default: s1_value = {24'd0, ram_rdata[7:0]};
                    endcase
                end
                SIZE_HALF: begin
                    s1_value = r_s1_lane[1] ? {16'd0, ram_rdata[15:0]}
                                            : {16'd0, ram_rdata[31:16]};
                end
                default: s1_value = ram_rdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op     <= i_in.op;
            r_s1_size   <= i_in.size;
            r_s1_lane   <= offset[1:0];
            r_s1_status <= req_status;
        end
        if (s1_adv) begin
            r_out_data   <= s1_value;
            r_out_status <= r_s1_status;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;
    assign o_out.status    = r_out_status;

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_OK) |-> (r_out_data == 32'd0))
        else $error("error result carries nonzero data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted access lost before output stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(ram_rdata)))
        else $error("pending read data changed during a stall");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_ctl.wr |-> (req_status == STATUS_OK && accept))
        else $error("memory written by a rejected access");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline valid bits survive reset");

endmodule

/* sv/sbma_ram.sv */
// Word-wide byte-lane memory holding all three stores, with a registered read.
module sbma_ram #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  sbma_pkg::t_ram_ctl   i_ctl,
    input  logic [ADDR_BITS-1:0] i_addr,
    input  logic [31:0]          i_wdata,
    output logic [31:0]          o_rdata
);
    import sbma_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (i_ctl.wr && i_ctl.byte_en[i]) begin
                r_mem[i_addr][31-8*i -: 8] <= i_wdata[31-8*i -: 8];
            end
        end
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* verif/segmented_byte_memory_access_test.sv */
// Self-checking testbench for the segmented big-endian byte memory access block.
module segmented_byte_memory_access_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbma_pkg::*;

    localparam int OFFSET_BITS = 16;
    localparam int STORE_DEPTH = 1 << OFFSET_BITS;
    localparam int MAX_GAP     = 20;
    localparam int PHASE_ITEMS = 370;

    typedef struct packed {
        logic        op;
        logic [31:0] address;
        logic [31:0] write_data;
        t_size       size;
    } t_access;

    typedef struct packed {
        logic [31:0] read_data;
        t_status     status;
    } t_result;

    typedef struct {
        t_status                  status;
        t_region_sel              sel;
        logic [OFFSET_BITS-1:0]   base;
        int                       nbytes;
    } t_decoded;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbma_in_if  access_if ();
    sbma_out_if result_if ();

    segmented_byte_memory_access #(
        .OFFSET_BITS(OFFSET_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (access_if),
        .o_out  (result_if)
    );

    // Shadow of every byte written so far, keyed by store select and offset.
    logic [7:0] shadow_bytes [bit [OFFSET_BITS+1:0]];
    t_result    pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int reads_ok       = 0;
    int writes_ok      = 0;
    int rejected       = 0;

    always #2 i_clk = ~i_clk;

    function automatic t_decoded decode_access(t_access acc);
        t_decoded    d;
        logic [19:0] offset;
        d.status = STATUS_OK;
        d.sel    = SEL_PROGRAM;
        d.base   = '0;
        d.nbytes = 1 << acc.size;
        if (acc.size == SIZE_INVALID) begin
            d.status = STATUS_BAD_SIZE;
            return d;
        end
        case (acc.address[31:20])
            REGION_PROGRAM: d.sel = SEL_PROGRAM;
            REGION_DATA:    d.sel = SEL_DATA;
            REGION_STACK:   d.sel = SEL_STACK;
            default: begin
                d.status = STATUS_UNMAPPED;
                return d;
            end
        endcase
        offset = acc.address[19:0] & ~20'(d.nbytes - 1);
        if ((offset >> OFFSET_BITS) != 0) begin
            d.status = STATUS_BEYOND;
        end else begin
            d.base = offset[OFFSET_BITS-1:0];
        end
        return d;
    endfunction

    function automatic bit [OFFSET_BITS+1:0] byte_key(t_decoded d, int i);
        return {d.sel, d.base + OFFSET_BITS'(i)};
    endfunction

    // Applies one access to the shadow stores and returns the result it must produce.
    function automatic t_result compute_access(t_access acc);
        t_decoded d;
        t_result  res;
        d = decode_access(acc);
        res.read_data = '0;
        res.status    = d.status;
        if (d.status == STATUS_OK) begin
            if (acc.op == OP_WRITE) begin
                for (int i = 0; i < d.nbytes; i++) begin
                    shadow_bytes[byte_key(d, i)] = acc.write_data[8*(d.nbytes-1-i) +: 8];
                end
                res.read_data = 32'd1;
            end else begin
                for (int i = 0; i < d.nbytes; i++) begin
                    res.read_data = {res.read_data[23:0], shadow_bytes[byte_key(d, i)]};
                end
            end
        end
        return res;
    endfunction

    function automatic bit is_readable(t_access acc);
        t_decoded d;
        d = decode_access(acc);
        if (d.status != STATUS_OK) begin
            return 1'b1;
        end
        for (int i = 0; i < d.nbytes; i++) begin
            if (!shadow_bytes.exists(byte_key(d, i))) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_access make_access(logic op, logic [31:0] address,
                                            logic [31:0] write_data, t_size size);
        t_access acc;
        acc.op         = op;
        acc.address    = address;
        acc.write_data = write_data;
        acc.size       = size;
        return acc;
    endfunction

    // Mostly valid accesses clustered in a few windows so reads find written bytes;
    // the rest are bad sizes, unmapped regions and offsets past the store.
    function automatic t_access random_access();
        t_access     acc;
        int          kind;
        logic [11:0] region;
        logic [19:0] offset;
        acc.op         = 1'($urandom_range(1));
        acc.write_data = $urandom;
        acc.size       = t_size'($urandom_range(2));
        case ($urandom_range(2))
            0:       region = REGION_PROGRAM;
            1:       region = REGION_DATA;
            default: region = REGION_STACK;
        endcase
        kind = $urandom_range(99);
        if (kind < 80) begin
            case ($urandom_range(3))
                0:       offset = 20'($urandom_range(255));
                1:       offset = 20'(STORE_DEPTH - 256 + $urandom_range(255));
                2:       offset = 20'(12'h800 + $urandom_range(63));
                default: offset = 20'($urandom_range(STORE_DEPTH - 1));
            endcase
        end else if (kind < 88) begin
            acc.size = SIZE_INVALID;
            offset   = 20'($urandom);
            if ($urandom_range(1) == 0) begin
                region = 12'($urandom);
            end
        end else if (kind < 94) begin
            region = 12'($urandom);
            if (region == REGION_PROGRAM || region == REGION_DATA || region == REGION_STACK) begin
                region = region ^ 12'h800;
            end
            offset = 20'($urandom);
        end else begin
            offset = 20'($urandom);
            if (offset[19:16] == 4'd0) begin
                offset[19:16] = 4'($urandom_range(15, 1));
            end
        end
        acc.address = {region, offset};
        if (acc.op == OP_READ && !is_readable(acc)) begin
            acc.op = OP_WRITE;
        end
        return acc;
    endfunction

    // Offers one access after a random idle gap and records its expected result.
    task automatic send_access(t_access acc);
        int      gap;
        t_result res;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            access_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        access_if.valid      <= 1'b1;
        access_if.op         <= acc.op;
        access_if.address    <= acc.address;
        access_if.write_data <= acc.write_data;
        access_if.size       <= acc.size;
        do @(posedge i_clk); while (!access_if.ready);
        res = compute_access(acc);
        pending_results.push_back(res);
        if (res.status != STATUS_OK) begin
            rejected++;
        end else if (acc.op == OP_WRITE) begin
            writes_ok++;
        end else begin
            reads_ok++;
        end
    endtask

    // Stops offering so the last access is not transferred again, then waits.
    task automatic wait_drained();
        access_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Checks each result transfer and drives the receiver's ready.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result read_data %h status %0d", $time,
                         result_if.read_data, result_if.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (result_if.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time,
                             want.read_data, result_if.read_data);
                    mismatch_count++;
                end
                if (result_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, result_if.status);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            result_if.ready <= 1'b0;
            hold_left--;
        end else begin
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_access(make_access(OP_WRITE, {REGION_DATA, 20'h00000}, 32'hDEADBEEF, SIZE_WORD));
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00000}, 32'h0, SIZE_WORD));
        // Unaligned half and word addresses drop their low offset bits.
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00003}, 32'h0, SIZE_HALF));
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00001}, 32'h0, SIZE_BYTE));
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00003}, 32'h0, SIZE_WORD));
        send_access(make_access(OP_WRITE, {REGION_PROGRAM, 20'(STORE_DEPTH - 1)},
                                32'hFFFFFFFF, SIZE_BYTE));
        send_access(make_access(OP_READ,  {REGION_PROGRAM, 20'(STORE_DEPTH - 1)},
                                32'h0, SIZE_BYTE));
        send_access(make_access(OP_WRITE, {REGION_STACK, 20'(STORE_DEPTH - 1)},
                                32'hFFFFA55A, SIZE_HALF));
        send_access(make_access(OP_READ,  {REGION_STACK, 20'(STORE_DEPTH - 1)},
                                32'h0, SIZE_HALF));
        send_access(make_access(OP_WRITE, {REGION_PROGRAM, 20'(STORE_DEPTH - 1)},
                                32'h01234567, SIZE_WORD));
        send_access(make_access(OP_READ,  {REGION_PROGRAM, 20'(STORE_DEPTH - 1)},
                                32'h0, SIZE_BYTE));
        send_access(make_access(OP_READ,  {REGION_PROGRAM, 20'(STORE_DEPTH - 2)},
                                32'h0, SIZE_WORD));
        // A bad size wins over an unmapped region, which wins over a bad offset.
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00000}, 32'h0, SIZE_INVALID));
        send_access(make_access(OP_WRITE, 32'hFFFFFFFF, 32'hFFFFFFFF, SIZE_INVALID));
        send_access(make_access(OP_READ,  32'h00000000, 32'h0, SIZE_BYTE));
        send_access(make_access(OP_WRITE, 32'hFFFFFFFF, 32'h12345678, SIZE_WORD));
        send_access(make_access(OP_READ,  {REGION_DATA, 20'(STORE_DEPTH)}, 32'h0, SIZE_WORD));
        send_access(make_access(OP_WRITE, {REGION_STACK, 20'hFFFFF}, 32'hAA, SIZE_BYTE));
        send_access(make_access(OP_WRITE, {REGION_DATA, 20'h00000}, 32'h00000000, SIZE_WORD));
        send_access(make_access(OP_READ,  {REGION_DATA, 20'h00002}, 32'h0, SIZE_WORD));
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS) send_access(random_access());
        wait_drained();
    endtask

    // A long output hold fills the pipeline while the sender keeps offering.
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (60) send_access(random_access());
        wait_drained();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        access_if.valid      = 1'b0;
        access_if.op         = OP_READ;
        access_if.address    = '0;
        access_if.write_data = '0;
        access_if.size       = SIZE_BYTE;
        result_if.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_phase(0, 0);
        test_random_phase(65, 0);
        test_random_phase(0, 65);
        test_random_phase(29, 29);
        test_output_hold();

        wait_drained();
        $display("Checked %0d reads, %0d writes and %0d rejected accesses.",
                 reads_ok, writes_ok, rejected);
        $display("Covered back-to-back traffic, input gaps, output stalls and a long hold.");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Run timed out with %0d results outstanding.", pending_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
